// ===== hw/rtl/keyboard_report_change_detect_unit_assert.svh =====
// Assertion macros used by the keyboard report change detector back end.
`ifndef KEYBOARD_REPORT_CHANGE_DETECT_UNIT_ASSERT_SVH
`define KEYBOARD_REPORT_CHANGE_DETECT_UNIT_ASSERT_SVH

// Same-cycle implication, checked on clk, off while rst_n is low.
`define KBRCD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off while rst_n is low.
`define KBRCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/kbrcd_pkg.sv =====
// Package for the keyboard report change detector: widths, codes, queue entry type.
package kbrcd_pkg;

  localparam int MAX_SLOTS   = 6;
  localparam int KEY_W       = 8;
  localparam int CNT_W       = 3;
  localparam int MOD_W       = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam int KEY_SLOTS_DEF = 6;

  localparam logic [KEY_W-1:0] FIRST_KEY_CODE = 8'h04;

  localparam logic [CNT_W-1:0] SLOTS_USED_RST = 3'd6;
  localparam logic [MOD_W-1:0] MOD_MASK_RST   = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_SLOTS_USED   = 1'b0,
    CFG_MOD_PRESENT_MASK = 1'b1
  } cfg_reg_t;

  // One classified report: sorted keys (unused lanes zero), key count, modifier bits.
  typedef struct packed {
    logic [MAX_SLOTS-1:0][KEY_W-1:0] keys;
    logic [CNT_W-1:0]                count;
    logic [MOD_W-1:0]                mods;
  } kbrcd_entry_t;

  localparam int ENTRY_W = $bits(kbrcd_entry_t);

endpackage

// ===== hw/rtl/kbrcd_front.sv =====
// Front end: drops unused slots and non-key codes, sorts the rest ascending.
module kbrcd_front #(
  parameter int KEY_SLOTS = kbrcd_pkg::KEY_SLOTS_DEF
) (
  input  logic [kbrcd_pkg::MAX_SLOTS-1:0][kbrcd_pkg::KEY_W-1:0] slot_codes,
  input  logic [kbrcd_pkg::MOD_W-1:0]                           mod_bits,
  input  logic [kbrcd_pkg::CNT_W-1:0]                           slots_used,
  output kbrcd_pkg::kbrcd_entry_t                               entry
);

  localparam int SORT_W = kbrcd_pkg::KEY_W + 1;
  localparam logic [kbrcd_pkg::CNT_W-1:0] SLOTS_MAX = kbrcd_pkg::CNT_W'(KEY_SLOTS);

  logic [kbrcd_pkg::CNT_W-1:0] slots_eff;

  assign slots_eff = (slots_used > SLOTS_MAX) ? SLOTS_MAX : slots_used;

  // Dropped lanes carry a set top bit so they sort to the end and read as zero.
  always_comb begin
    logic [KEY_SLOTS-1:0][SORT_W-1:0] v;
    logic [SORT_W-1:0]                tmp;
    logic [kbrcd_pkg::CNT_W-1:0]      n;
    n   = '0;
    tmp = '0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if ((kbrcd_pkg::CNT_W'(i) < slots_eff) &&
          (slot_codes[i] >= kbrcd_pkg::FIRST_KEY_CODE)) begin
        v[i] = {1'b0, slot_codes[i]};
        n    = n + 1'b1;
      end else begin
        v[i] = {1'b1, {kbrcd_pkg::KEY_W{1'b0}}};
      end
    end
    // odd-even transposition network, KEY_SLOTS rounds
    for (int r = 0; r < KEY_SLOTS; r++) begin
      for (int i = r % 2; i + 1 < KEY_SLOTS; i += 2) begin
        if (v[i] > v[i+1]) begin
          tmp    = v[i];
          v[i]   = v[i+1];
          v[i+1] = tmp;
        end
      end
    end
    entry.keys = '0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      entry.keys[i] = v[i][kbrcd_pkg::KEY_W-1:0];
    end
    entry.count = n;
    entry.mods  = mod_bits;
  end

endmodule

// ===== hw/rtl/kbrcd_fifo.sv =====
// Small register queue between the front end and the state-update back end.
module kbrcd_fifo #(
  parameter int WIDTH = kbrcd_pkg::ENTRY_W,
  parameter int DEPTH = kbrcd_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == FULL_CNT);
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== hw/rtl/kbrcd_back.sv =====
// Back end: compares a sorted report with the held set and modifiers, updates them.
`include "keyboard_report_change_detect_unit_assert.svh"

module kbrcd_back #(
  parameter int KEY_SLOTS = kbrcd_pkg::KEY_SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  kbrcd_pkg::kbrcd_entry_t      q_entry,
  output logic                         q_pop,
  input  logic [kbrcd_pkg::MOD_W-1:0]  mod_mask,
  output logic                         res_valid,
  input  logic                         res_ready,
  output logic                         res_changed,
  output kbrcd_pkg::kbrcd_entry_t      res_state
);

  logic                                                  out_valid_r, out_valid_nxt;
  logic                                                  changed_r, changed_nxt;
  logic [kbrcd_pkg::MAX_SLOTS-1:0][kbrcd_pkg::KEY_W-1:0] held_keys_r, held_keys_nxt;
  logic [kbrcd_pkg::CNT_W-1:0]                           held_count_r, held_count_nxt;
  logic [kbrcd_pkg::MOD_W-1:0]                           held_mods_r, held_mods_nxt;
  logic                                                  keys_diff;
  logic [kbrcd_pkg::MOD_W-1:0]                           mod_diff;

  // Lanes past the count are zero on both sides, so a whole-array compare is exact.
  assign keys_diff = (q_entry.count != held_count_r) || (q_entry.keys != held_keys_r);
  assign mod_diff  = (q_entry.mods ^ held_mods_r) & mod_mask;
  assign q_pop     = q_valid && (!out_valid_r || res_ready);

  always_comb begin
    out_valid_nxt  = out_valid_r;
    changed_nxt    = changed_r;
    held_keys_nxt  = held_keys_r;
    held_count_nxt = held_count_r;
    held_mods_nxt  = held_mods_r;
    if (res_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (q_pop) begin
      out_valid_nxt = 1'b1;
      changed_nxt   = keys_diff || (mod_diff != '0);
      held_mods_nxt = held_mods_r ^ mod_diff;
      if (keys_diff) begin
        held_keys_nxt  = q_entry.keys;
        held_count_nxt = q_entry.count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      changed_r    <= 1'b0;
      held_keys_r  <= '0;
      held_count_r <= '0;
      held_mods_r  <= '0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      changed_r    <= changed_nxt;
      held_keys_r  <= held_keys_nxt;
      held_count_r <= held_count_nxt;
      held_mods_r  <= held_mods_nxt;
    end
  end

  // Result is the held state itself; it only moves when a new report is popped.
  assign res_valid       = out_valid_r;
  assign res_changed     = changed_r;
  assign res_state.keys  = held_keys_r;
  assign res_state.count = held_count_r;
  assign res_state.mods  = held_mods_r;

  `KBRCD_ASSERT_IMPL(a_count_range, 1'b1, held_count_r <= kbrcd_pkg::CNT_W'(KEY_SLOTS), "held count above slot count")
  `KBRCD_ASSERT_NEXT(a_pop_shows, q_pop, out_valid_r, "popped report gave no result")
  `KBRCD_ASSERT_NEXT(a_quiet_keeps, q_pop && !changed_nxt, $stable(held_keys_r) && $stable(held_count_r) && $stable(held_mods_r), "state moved on unchanged report")
  `KBRCD_ASSERT_NEXT(a_stall_keeps, out_valid_r && !res_ready, $stable(held_keys_r) && $stable(changed_r), "held state moved under a stalled result")

endmodule

// ===== hw/rtl/keyboard_report_change_detect_unit.sv =====
// Top level of the keyboard report change detector.
//
//  channel  direction  handshake              payload
//  in_      input      in_valid / in_ready    six key slots, modifier bits
//  out_     output     out_valid / out_ready  changed, count, sorted keys, modifiers
//  cfg_     input      cfg_we (no wait)       cfg_index, cfg_wdata
//
// One report per cycle sustained while out_ready stays high; the held key set /
// modifier update in the back end is the registered loop that sets this rate. A
// report is queued, and its result is registered when the back end pops it.
// Reset is synchronous on rst_n low; held state clears at once, no clearing pass.
// A two-entry queue parts front and back, so in_ready stays high while a result
// waits on out_ready until the queue fills.
module keyboard_report_change_detect_unit #(
  parameter int KEY_SLOTS = kbrcd_pkg::KEY_SLOTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // report input
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [kbrcd_pkg::KEY_W-1:0]        in_key_slot_0,
  input  logic [kbrcd_pkg::KEY_W-1:0]        in_key_slot_1,
  input  logic [kbrcd_pkg::KEY_W-1:0]        in_key_slot_2,
  input  logic [kbrcd_pkg::KEY_W-1:0]        in_key_slot_3,
  input  logic [kbrcd_pkg::KEY_W-1:0]        in_key_slot_4,
  input  logic [kbrcd_pkg::KEY_W-1:0]        in_key_slot_5,
  input  logic [kbrcd_pkg::MOD_W-1:0]        in_modifier_bits,
  // result output
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_changed,
  output logic [kbrcd_pkg::CNT_W-1:0]        out_key_count,
  output logic [kbrcd_pkg::KEY_W-1:0]        out_sorted_key_0,
  output logic [kbrcd_pkg::KEY_W-1:0]        out_sorted_key_1,
  output logic [kbrcd_pkg::KEY_W-1:0]        out_sorted_key_2,
  output logic [kbrcd_pkg::KEY_W-1:0]        out_sorted_key_3,
  output logic [kbrcd_pkg::KEY_W-1:0]        out_sorted_key_4,
  output logic [kbrcd_pkg::KEY_W-1:0]        out_sorted_key_5,
  output logic [kbrcd_pkg::MOD_W-1:0]        out_modifiers_down,
  // configuration
  input  logic                               cfg_we,
  input  logic [kbrcd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kbrcd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  // config registers
  logic [kbrcd_pkg::CNT_W-1:0] slots_used_r, slots_used_nxt;
  logic [kbrcd_pkg::MOD_W-1:0] mod_mask_r, mod_mask_nxt;

  logic [kbrcd_pkg::MAX_SLOTS-1:0][kbrcd_pkg::KEY_W-1:0] slot_codes;
  kbrcd_pkg::kbrcd_entry_t                               front_entry;
  kbrcd_pkg::kbrcd_entry_t                               q_entry;
  kbrcd_pkg::kbrcd_entry_t                               res_state;
  logic [kbrcd_pkg::ENTRY_W-1:0]                         q_rdata;
  logic                                                  q_full;
  logic                                                  q_empty;
  logic                                                  q_pop;
  logic                                                  push;

  always_comb begin
    slots_used_nxt = slots_used_r;
    mod_mask_nxt   = mod_mask_r;
    if (cfg_we) begin
      unique case (kbrcd_pkg::cfg_reg_t'(cfg_index))
        kbrcd_pkg::CFG_KEY_SLOTS_USED:   slots_used_nxt = cfg_wdata[kbrcd_pkg::CNT_W-1:0];
        kbrcd_pkg::CFG_MOD_PRESENT_MASK: mod_mask_nxt   = cfg_wdata[kbrcd_pkg::MOD_W-1:0];
        default: begin
          slots_used_nxt = slots_used_r;
          mod_mask_nxt   = mod_mask_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_used_r <= kbrcd_pkg::SLOTS_USED_RST;
      mod_mask_r   <= kbrcd_pkg::MOD_MASK_RST;
    end else begin
      slots_used_r <= slots_used_nxt;
      mod_mask_r   <= mod_mask_nxt;
    end
  end

  assign slot_codes[0] = in_key_slot_0;
  assign slot_codes[1] = in_key_slot_1;
  assign slot_codes[2] = in_key_slot_2;
  assign slot_codes[3] = in_key_slot_3;
  assign slot_codes[4] = in_key_slot_4;
  assign slot_codes[5] = in_key_slot_5;

  // Queue space is the only thing that holds off a new report.
  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  kbrcd_front #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_front (
    .slot_codes (slot_codes),
    .mod_bits   (in_modifier_bits),
    .slots_used (slots_used_r),
    .entry      (front_entry)
  );

  kbrcd_fifo #(
    .WIDTH (kbrcd_pkg::ENTRY_W),
    .DEPTH (kbrcd_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (front_entry),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  assign q_entry = kbrcd_pkg::kbrcd_entry_t'(q_rdata);

  kbrcd_back #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (!q_empty),
    .q_entry     (q_entry),
    .q_pop       (q_pop),
    .mod_mask    (mod_mask_r),
    .res_valid   (out_valid),
    .res_ready   (out_ready),
    .res_changed (out_changed),
    .res_state   (res_state)
  );

  assign out_key_count      = res_state.count;
  assign out_sorted_key_0   = res_state.keys[0];
  assign out_sorted_key_1   = res_state.keys[1];
  assign out_sorted_key_2   = res_state.keys[2];
  assign out_sorted_key_3   = res_state.keys[3];
  assign out_sorted_key_4   = res_state.keys[4];
  assign out_sorted_key_5   = res_state.keys[5];
  assign out_modifiers_down = res_state.mods;

endmodule

// ===== test/keyboard_report_change_detect_unit_tb.sv =====
// Self-checking testbench for the keyboard report change detector top level.
`timescale 1ns / 100ps

module keyboard_report_change_detect_unit_tb;
  import kbrcd_pkg::*;

  // Cycles with no transfer on either channel before the run is declared hung.
  localparam int STALL_LIMIT = 2000;
  // Padding after the last result is back, for the tail.
  localparam int DRAIN_CYCLES = 4;

  // One keyboard report as it goes onto the in_ channel.
  typedef struct packed {
    logic [MAX_SLOTS-1:0][KEY_W-1:0] slot;
    logic [MOD_W-1:0]                mods;
  } report_t;

  // What the out_ channel should carry for one report.
  typedef struct packed {
    logic                            changed;
    logic [CNT_W-1:0]                count;
    logic [MAX_SLOTS-1:0][KEY_W-1:0] keys;
    logic [MOD_W-1:0]                mods;
  } key_state_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [KEY_W-1:0] in_key_slot_0 = '0;
  logic [KEY_W-1:0] in_key_slot_1 = '0;
  logic [KEY_W-1:0] in_key_slot_2 = '0;
  logic [KEY_W-1:0] in_key_slot_3 = '0;
  logic [KEY_W-1:0] in_key_slot_4 = '0;
  logic [KEY_W-1:0] in_key_slot_5 = '0;
  logic [MOD_W-1:0] in_modifier_bits = '0;

  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             out_changed;
  logic [CNT_W-1:0] out_key_count;
  logic [KEY_W-1:0] out_sorted_key_0;
  logic [KEY_W-1:0] out_sorted_key_1;
  logic [KEY_W-1:0] out_sorted_key_2;
  logic [KEY_W-1:0] out_sorted_key_3;
  logic [KEY_W-1:0] out_sorted_key_4;
  logic [KEY_W-1:0] out_sorted_key_5;
  logic [MOD_W-1:0] out_modifiers_down;

  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Idle rates in percent, changed per phase.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  int fail_count = 0;
  int stall_cycles = 0;

  // Predictor copy of the registers (reset values) and the held state.
  logic [CNT_W-1:0]         slots_used = SLOTS_USED_RST;
  logic [MOD_W-1:0]         mod_mask = MOD_MASK_RST;
  logic [KEY_W-1:0]         kept_keys [MAX_SLOTS];
  int                       kept_count = 0;
  logic [MOD_W-1:0]         kept_mods = '0;

  // Last report generated; random reports are mostly derived from it.
  report_t last_report = '0;

  // Expected results, oldest first.
  key_state_t due_results [$];

  keyboard_report_change_detect_unit u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_key_slot_0      (in_key_slot_0),
    .in_key_slot_1      (in_key_slot_1),
    .in_key_slot_2      (in_key_slot_2),
    .in_key_slot_3      (in_key_slot_3),
    .in_key_slot_4      (in_key_slot_4),
    .in_key_slot_5      (in_key_slot_5),
    .in_modifier_bits   (in_modifier_bits),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_changed        (out_changed),
    .out_key_count      (out_key_count),
    .out_sorted_key_0   (out_sorted_key_0),
    .out_sorted_key_1   (out_sorted_key_1),
    .out_sorted_key_2   (out_sorted_key_2),
    .out_sorted_key_3   (out_sorted_key_3),
    .out_sorted_key_4   (out_sorted_key_4),
    .out_sorted_key_5   (out_sorted_key_5),
    .out_modifiers_down (out_modifiers_down),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver backpressure: one draw per cycle, one assignment per step.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    foreach (kept_keys[i]) kept_keys[i] = '0;
  end

  // Applies one report to the held key set and modifiers and returns what the
  // block should report for it.
  function automatic key_state_t track_report(input report_t r);
    logic [KEY_W-1:0] fresh [MAX_SLOTS];
    logic [KEY_W-1:0] code;
    logic [MOD_W-1:0] diff;
    int               n;
    int               j;
    int               slots;
    logic             chg;
    key_state_t       res;
    // Slot count above the synthesized slot number saturates.
    slots = (slots_used > KEY_SLOTS_DEF) ? KEY_SLOTS_DEF : int'(slots_used);
    n = 0;
    chg = 1'b0;
    foreach (fresh[i]) fresh[i] = '0;
    // Empty, error rollover and reserved codes (below 0x04) are dropped.
    for (int i = 0; i < slots; i++) begin
      if (r.slot[i] >= FIRST_KEY_CODE) begin
        fresh[n] = r.slot[i];
        n++;
      end
    end
    // Ascending, duplicates kept.
    for (int i = 1; i < n; i++) begin
      code = fresh[i];
      j = i;
      while (j > 0 && fresh[j-1] > code) begin
        fresh[j] = fresh[j-1];
        j--;
      end
      fresh[j] = code;
    end
    if (n != kept_count) begin
      chg = 1'b1;
    end else begin
      for (int i = 0; i < n; i++) begin
        if (fresh[i] != kept_keys[i]) chg = 1'b1;
      end
    end
    if (chg) begin
      kept_keys = fresh;
      kept_count = n;
    end
    // Absent modifiers are neither compared nor updated.
    diff = (r.mods ^ kept_mods) & mod_mask;
    if (diff != '0) begin
      kept_mods = kept_mods ^ diff;
      chg = 1'b1;
    end
    res.changed = chg;
    res.count = CNT_W'(kept_count);
    for (int i = 0; i < MAX_SLOTS; i++) begin
      res.keys[i] = (i < kept_count) ? kept_keys[i] : '0;
    end
    res.mods = kept_mods;
    return res;
  endfunction

  function automatic report_t make_report(input logic [KEY_W-1:0] s0, s1, s2, s3, s4, s5,
                                          input logic [MOD_W-1:0] mods);
    report_t r;
    r.slot[0] = s0;
    r.slot[1] = s1;
    r.slot[2] = s2;
    r.slot[3] = s3;
    r.slot[4] = s4;
    r.slot[5] = s5;
    r.mods = mods;
    return r;
  endfunction

  // Skewed toward empty, rollover/reserved and boundary codes.
  function automatic logic [KEY_W-1:0] pick_code();
    int roll;
    roll = $urandom_range(99);
    if (roll < 30) return '0;
    if (roll < 38) return KEY_W'($urandom_range(1, 3));
    if (roll < 41) return FIRST_KEY_CODE;
    if (roll < 44) return '1;
    return KEY_W'($urandom_range(4, 255));
  endfunction

  // Mostly a key press or release on top of the last report, so the held set
  // sees both real changes and reports that change nothing.
  function automatic report_t next_report();
    report_t r;
    logic [KEY_W-1:0] tmp;
    int roll;
    int a;
    int b;
    r = last_report;
    roll = $urandom_range(99);
    if (roll < 20) begin
      // same report again
    end else if (roll < 35) begin
      // same codes, other slot order
      repeat ($urandom_range(1, 4)) begin
        a = $urandom_range(MAX_SLOTS - 1);
        b = $urandom_range(MAX_SLOTS - 1);
        tmp = r.slot[a];
        r.slot[a] = r.slot[b];
        r.slot[b] = tmp;
      end
    end else if (roll < 65) begin
      r.slot[$urandom_range(MAX_SLOTS - 1)] = pick_code();
    end else if (roll < 90) begin
      for (int i = 0; i < MAX_SLOTS; i++) r.slot[i] = pick_code();
    end else begin
      // plain noise
      for (int i = 0; i < MAX_SLOTS; i++) r.slot[i] = KEY_W'($urandom_range(255));
    end
    roll = $urandom_range(99);
    if (roll < 50) begin
      // modifiers held
    end else if (roll < 80) begin
      r.mods[$urandom_range(MOD_W - 1)] ^= 1'b1;
    end else begin
      r.mods = MOD_W'($urandom_range(255));
    end
    last_report = r;
    return r;
  endfunction

  // Presents one report and waits for its transfer. in_valid is only lowered
  // in idle cycles, so back-to-back reports keep it high.
  task automatic send_report(input report_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_key_slot_0 <= r.slot[0];
    in_key_slot_1 <= r.slot[1];
    in_key_slot_2 <= r.slot[2];
    in_key_slot_3 <= r.slot[3];
    in_key_slot_4 <= r.slot[4];
    in_key_slot_5 <= r.slot[5];
    in_modifier_bits <= r.mods;
    do @(posedge clk); while (!in_ready);
    due_results.push_back(track_report(r));
  endtask

  // Brings the block to idle: no report offered, every result back.
  task automatic drain();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write; only called with the block idle. The trailing edge keeps
  // back-to-back writes from assigning cfg_we twice in one step.
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_KEY_SLOTS_USED:   slots_used = data[CNT_W-1:0];
      CFG_MOD_PRESENT_MASK: mod_mask = data;
      default: ;
    endcase
  endtask

  // Reset values of both registers: all six slots, all modifiers present.
  task automatic test_reset_defaults();
    send_report(make_report(8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h00));
    send_report(make_report(8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h00));
  endtask

  // Field extremes, duplicates, reordering, rollover and modifier-only changes.
  task automatic test_report_codes();
    send_report(make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF));
    send_report(make_report(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00));
    send_report(make_report(8'h10, 8'h04, 8'h10, 8'h01, 8'h03, 8'h02, 8'h00));
    // same set in another order: no change
    send_report(make_report(8'h02, 8'h10, 8'h00, 8'h10, 8'h04, 8'h01, 8'h00));
    // error rollover in every slot empties the set
    send_report(make_report(8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h00));
    send_report(make_report(8'h03, 8'h04, 8'hFE, 8'hFF, 8'h00, 8'h80, 8'h00));
    // modifier only
    send_report(make_report(8'h03, 8'h04, 8'hFE, 8'hFF, 8'h00, 8'h80, 8'h80));
    send_report(make_report(8'h03, 8'h04, 8'hFE, 8'hFF, 8'h00, 8'h80, 8'h80));
    send_report(make_report(8'h80, 8'h7F, 8'h01, 8'hAA, 8'h55, 8'h04, 8'h01));
  endtask

  // Slot count 0, 1 (upper data bits set), 7 (saturates) and 3.
  task automatic test_slot_count();
    drain();
    write_reg(CFG_KEY_SLOTS_USED, 8'h00);
    send_report(make_report(8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h00));
    drain();
    write_reg(CFG_KEY_SLOTS_USED, 8'hF9);
    send_report(make_report(8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h00));
    drain();
    write_reg(CFG_KEY_SLOTS_USED, 8'h07);
    send_report(make_report(8'h09, 8'h08, 8'h07, 8'h06, 8'h05, 8'h04, 8'h00));
    drain();
    write_reg(CFG_KEY_SLOTS_USED, 8'h03);
    send_report(make_report(8'h09, 8'h08, 8'h07, 8'h06, 8'h05, 8'h04, 8'h00));
  endtask

  // Absent modifiers keep their held value.
  task automatic test_modifier_mask();
    drain();
    write_reg(CFG_MOD_PRESENT_MASK, 8'h00);
    send_report(make_report(8'h09, 8'h08, 8'h07, 8'h00, 8'h00, 8'h00, 8'hFF));
    drain();
    write_reg(CFG_MOD_PRESENT_MASK, 8'hA5);
    send_report(make_report(8'h09, 8'h08, 8'h07, 8'h00, 8'h00, 8'h00, 8'h5A));
    drain();
    write_reg(CFG_MOD_PRESENT_MASK, 8'hFF);
    write_reg(CFG_KEY_SLOTS_USED, 8'h06);
    send_report(make_report(8'h09, 8'h08, 8'h07, 8'h00, 8'h00, 8'h00, 8'h00));
  endtask

  // Random reports in chunks, with fresh register values between chunks.
  task automatic test_random_reports(input int send_pct, input int recv_pct);
    logic [CFG_DATA_W-1:0] data;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int chunk = 0; chunk < 4; chunk++) begin
      drain();
      data = CFG_DATA_W'($urandom_range(255));
      if ($urandom_range(99) < 60) data[CNT_W-1:0] = SLOTS_USED_RST;
      write_reg(CFG_KEY_SLOTS_USED, data);
      data = CFG_DATA_W'($urandom_range(255));
      if ($urandom_range(99) < 50) data = MOD_MASK_RST;
      else if ($urandom_range(99) < 25) data = '0;
      write_reg(CFG_MOD_PRESENT_MASK, data);
      repeat (108) send_report(next_report());
    end
  endtask

  // Each transfer on out_ is checked against the oldest expectation.
  task automatic check_field(input string name, input logic [KEY_W-1:0] want,
                             input logic [KEY_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%02h, got 0x%02h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    key_state_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        $error("result transfer with no report outstanding");
        fail_count++;
      end else begin
        want = due_results.pop_front();
        check_field("changed", KEY_W'(want.changed), KEY_W'(out_changed));
        check_field("key_count", KEY_W'(want.count), KEY_W'(out_key_count));
        check_field("sorted_key_0", want.keys[0], out_sorted_key_0);
        check_field("sorted_key_1", want.keys[1], out_sorted_key_1);
        check_field("sorted_key_2", want.keys[2], out_sorted_key_2);
        check_field("sorted_key_3", want.keys[3], out_sorted_key_3);
        check_field("sorted_key_4", want.keys[4], out_sorted_key_4);
        check_field("sorted_key_5", want.keys[5], out_sorted_key_5);
        check_field("modifiers_down", want.mods, out_modifiers_down);
      end
    end
  end

  // Hang detection: any transfer on either channel restarts the count.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("keyboard_report_change_detect_unit_tb NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part runs with the first idle mix so gaps hit it too.
    send_idle_pct = 17;
    recv_idle_pct = 68;
    test_reset_defaults();
    test_report_codes();
    test_slot_count();
    test_modifier_mask();

    test_random_reports(17, 68);
    test_random_reports(68, 17);
    test_random_reports(0, 0);

    drain();
    if (fail_count == 0 && due_results.size() == 0) begin
      $display("keyboard_report_change_detect_unit_tb OK");
    end else begin
      $display("keyboard_report_change_detect_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
